// File: rtl/core/plp_pkg.sv
// Shared types, codes and the capability name table of the POP3 reply line parser.
package plp_pkg;

  localparam logic [2:0] KIND_STATUS = 3'd0;
  localparam logic [2:0] KIND_STAT   = 3'd1;
  localparam logic [2:0] KIND_LIST   = 3'd2;
  localparam logic [2:0] KIND_UIDL   = 3'd3;
  localparam logic [2:0] KIND_CAPA   = 3'd4;

  localparam logic [3:0] PH_PRE    = 4'd0;
  localparam logic [3:0] PH_SEP    = 4'd1;
  localparam logic [3:0] PH_LEAD   = 4'd2;
  localparam logic [3:0] PH_TEXT   = 4'd3;
  localparam logic [3:0] PH_NUM1   = 4'd4;
  localparam logic [3:0] PH_NUM2   = 4'd5;
  localparam logic [3:0] PH_TAIL   = 4'd6;
  localparam logic [3:0] PH_FAIL   = 4'd7;
  localparam logic [3:0] PH_CNAME  = 4'd8;
  localparam logic [3:0] PH_CLEAD  = 4'd9;
  localparam logic [3:0] PH_CPARAM = 4'd10;

  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_PREFIX     = 4'd1;
  localparam logic [3:0] ERR_SEPARATOR  = 4'd2;
  localparam logic [3:0] ERR_CONTROL    = 4'd3;
  localparam logic [3:0] ERR_STAT       = 4'd4;
  localparam logic [3:0] ERR_LIST       = 4'd5;
  localparam logic [3:0] ERR_UIDL_NUM   = 4'd6;
  localparam logic [3:0] ERR_ID_CHAR    = 4'd7;
  localparam logic [3:0] ERR_EMPTY_ID   = 4'd8;
  localparam logic [3:0] ERR_CAP_NAME   = 4'd9;
  localparam logic [3:0] ERR_CAP_EMPTY  = 4'd10;
  localparam logic [3:0] ERR_CAP_CTRL   = 4'd11;
  localparam logic [3:0] ERR_TOO_LONG   = 4'd12;

  localparam int CAP_COUNT = 10;
  localparam logic [CAP_COUNT-1:0] MASK_ALL = '1;

  localparam logic [127:0] CAP_TEXT [CAP_COUNT] = '{
    {"TOP", 104'd0}, {"USER", 96'd0}, {"SASL", 96'd0}, {"RESP-CODES", 48'd0},
    {"LOGIN-DELAY", 40'd0}, {"PIPELINING", 48'd0}, {"EXPIRE", 80'd0},
    {"UIDL", 96'd0}, {"IMPLEMENTATION", 16'd0}, {"STLS", 96'd0}
  };
  localparam logic [3:0] CAP_LEN [CAP_COUNT] = '{
    4'd3, 4'd4, 4'd4, 4'd10, 4'd11, 4'd10, 4'd6, 4'd4, 4'd14, 4'd4
  };

  typedef struct packed {
    logic [2:0] line_kind;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       line_end;
  } plp_item_t;

  typedef struct packed {
    logic        reply_ok;
    logic [3:0]  error_code;
    logic [63:0] first_number;
    logic [63:0] second_number;
    logic [10:0] text_offset;
    logic [10:0] text_length;
    logic [10:0] name_length;
    logic [3:0]  capability_code;
  } plp_result_t;

  // Per-line parse state; offsets are kept modulo 2048 as the result fields are.
  typedef struct packed {
    logic [2:0]           kind;
    logic [3:0]           phase;
    logic [63:0]          value_one;
    logic [63:0]          value_two;
    logic                 digits_seen;
    logic [10:0]          slice_start;
    logic [10:0]          name_len;
    logic [CAP_COUNT-1:0] match_mask;
    logic [3:0]           error;
    logic                 ok;
  } plp_state_t;

  localparam plp_state_t STATE_RESET = '{
    kind: 3'd0, phase: PH_PRE, value_one: 64'd0, value_two: 64'd0,
    digits_seen: 1'b0, slice_start: 11'd0, name_len: 11'd0,
    match_mask: MASK_ALL, error: ERR_NONE, ok: 1'b0
  };

  function automatic logic [7:0] cap_char(input int idx, input logic [3:0] pos);
    logic [127:0] w;
    w = CAP_TEXT[idx];
    return w[127 - 8 * int'(pos) -: 8];
  endfunction

endpackage

// File: rtl/core/pop3_reply_line_parser.sv
// Top level of the POP3 reply line parser: input register, line state and result register.
//
//   channel  direction  handshake                  payload
//   line     in         line_valid / line_stall    line_item  (plp_item_t)
//   result   out        result_valid / result_stall result    (plp_result_t)
//
// One byte request is taken per cycle unless stalled; a line_end result is held in the result register.
// The request register feeds a single combinational step into the line state and result register.
// Reset (rst, synchronous) clears the line state, position and both valid flags.
// A stalled result holds; a line_end request then waits in the request register, while
// requests that end no line keep flowing.
module pop3_reply_line_parser import plp_pkg::*; #(
  parameter int LINE_MAX_BYTES = 1024
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        line_valid,
  output logic        line_stall,
  input  plp_item_t   line_item,
  output logic        result_valid,
  input  logic        result_stall,
  output plp_result_t result
);

  localparam int PW = $clog2(LINE_MAX_BYTES + 1);

  logic          req_valid;
  plp_item_t     req;
  plp_state_t    state, state_next;
  logic [PW-1:0] pos, pos_next;
  plp_result_t   step_result;
  logic          out_free, req_go;

  plp_step #(.LINE_MAX_BYTES(LINE_MAX_BYTES), .PW(PW)) u_step (
    .item       (req),
    .state      (state),
    .pos        (pos),
    .state_next (state_next),
    .pos_next   (pos_next),
    .result     (step_result)
  );

  assign out_free = !result_valid || !result_stall;
  assign req_go = req_valid && (!req.line_end || out_free);
  assign line_stall = req_valid && !req_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!line_stall) begin
      req_valid <= line_valid;
    end
    if (!line_stall && line_valid) begin
      req <= line_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
      pos <= '0;
    end else if (req_go) begin
      state <= state_next;
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_free) begin
      result_valid <= req_go && req.line_end;
    end
    if (out_free && req_go && req.line_end) begin
      result <= step_result;
    end
  end

`ifndef SYNTH
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= PW'(LINE_MAX_BYTES))
    else $error("line position beyond the limit");
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    req_go && req.line_end |=> pos == '0 && state.error == ERR_NONE)
    else $error("line state not cleared after line end");
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.error_code != ERR_NONE |->
      result.first_number == 64'd0 && result.text_length == 11'd0 &&
      result.capability_code == 4'd0 && !result.reply_ok)
    else $error("fields not cleared on error result");
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    line_stall |-> req_valid && req.line_end && result_valid && result_stall)
    else $error("request stalled without a blocked result");
`endif

endmodule

// File: rtl/core/plp_step.sv
// Next-state and result logic for one byte step of the reply line parser.
module plp_step import plp_pkg::*; #(
  parameter int LINE_MAX_BYTES = 1024,
  parameter int PW = $clog2(LINE_MAX_BYTES + 1)
) (
  input  plp_item_t   item,
  input  plp_state_t  state,
  input  logic [PW-1:0] pos,
  output plp_state_t  state_next,
  output logic [PW-1:0] pos_next,
  output plp_result_t result
);

  plp_state_t lat;
  plp_state_t ns;
  logic [PW-1:0] np;

  always_comb begin
    lat = state;
    if (pos == '0) begin
      lat.kind = (item.line_kind > KIND_CAPA) ? KIND_STATUS : item.line_kind;
      if (lat.kind == KIND_LIST || lat.kind == KIND_UIDL) begin
        lat.phase = PH_NUM1;
      end else if (lat.kind == KIND_CAPA) begin
        lat.phase = PH_CNAME;
      end else begin
        lat.phase = PH_PRE;
      end
    end
  end

  logic [7:0]  b;
  logic        ws, dig, idch, ctl;
  logic [63:0] acc_src;
  logic [67:0] acc;
  logic        ovf;

  assign b = item.data_byte;
  assign ws = (b == 8'd32) || (b == 8'd9);
  assign dig = (b >= 8'd48) && (b <= 8'd57);
  assign idch = (b > 8'd32) && (b < 8'd127);
  assign ctl = (b < 8'd32) || (b == 8'd127);
  assign acc_src = (lat.phase == PH_NUM2) ? lat.value_two : lat.value_one;
  assign acc = ({4'd0, acc_src} << 3) + ({4'd0, acc_src} << 1) + 68'(b[3:0]);
  assign ovf = |acc[67:64];

  always_comb begin
    logic [PW-1:0] p;
    logic [7:0]    up;
    logic [7:0]    want;
    logic          pair;
    ns = lat;
    np = pos;
    p = pos;
    up = (b >= 8'd97) ? b - 8'd32 : b;
    want = 8'd0;
    pair = 1'b0;
    if (item.byte_present && lat.error != ERR_TOO_LONG) begin
      if (pos >= PW'(LINE_MAX_BYTES)) begin
        ns.error = ERR_TOO_LONG;
      end else begin
        np = pos + 1'b1;
        if (lat.error == ERR_NONE) begin
          unique case (lat.kind)
            KIND_LIST: pair = 1'b1;
            KIND_UIDL: begin
              if (lat.phase == PH_NUM1) begin
                if (dig) begin
                  if (ovf) ns.error = ERR_UIDL_NUM;
                  else begin
                    ns.value_one = acc[63:0];
                    ns.digits_seen = 1'b1;
                  end
                end else if (ws) begin
                  if (lat.digits_seen) begin
                    if (lat.value_one == 64'd0) ns.error = ERR_UIDL_NUM;
                    else begin
                      ns.phase = PH_LEAD;
                      ns.slice_start = 11'(p + 1'b1);
                    end
                  end
                end else begin
                  ns.error = ERR_UIDL_NUM;
                end
              end else if (lat.phase == PH_LEAD) begin
                if (ws) ns.slice_start = 11'(p + 1'b1);
                else if (idch) ns.phase = PH_TEXT;
                else ns.error = ERR_ID_CHAR;
              end else if (!idch) begin
                ns.error = ERR_ID_CHAR;
              end
            end
            KIND_CAPA: begin
              if (lat.phase == PH_CNAME) begin
                if (ws) begin
                  if (p == '0) ns.error = ERR_CAP_EMPTY;
                  else begin
                    ns.name_len = 11'(p);
                    ns.phase = PH_CLEAD;
                    ns.slice_start = 11'(p + 1'b1);
                  end
                end else if (!((b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122)
                               || b == 8'd45)) begin
                  ns.error = ERR_CAP_NAME;
                end else begin
                  for (int i = 0; i < CAP_COUNT; i++) begin
                    if (p >= PW'(CAP_LEN[i]) || up != cap_char(i, p[3:0])) begin
                      ns.match_mask[i] = 1'b0;
                    end
                  end
                end
              end else if (lat.phase == PH_CLEAD) begin
                if (ws) ns.slice_start = 11'(p + 1'b1);
                else if (ctl) ns.error = ERR_CAP_CTRL;
                else ns.phase = PH_CPARAM;
              end else if (ctl) begin
                ns.error = ERR_CAP_CTRL;
              end
            end
            default: begin
              if (lat.phase == PH_PRE) begin
                if (p == '0) begin
                  if (b == 8'd43) ns.ok = 1'b1;
                  else if (b == 8'd45) ns.ok = 1'b0;
                  else ns.error = ERR_PREFIX;
                end else begin
                  if (lat.ok) begin
                    want = (p == PW'(1)) ? 8'd79 : 8'd75;
                  end else begin
                    want = (p == PW'(1)) ? 8'd69 : 8'd82;
                  end
                  if (p >= (lat.ok ? PW'(3) : PW'(4)) || b != want) begin
                    ns.error = ERR_PREFIX;
                  end else if (p == (lat.ok ? PW'(2) : PW'(3))) begin
                    ns.phase = PH_SEP;
                    ns.slice_start = lat.ok ? 11'd3 : 11'd4;
                  end
                end
              end else if (lat.phase == PH_SEP) begin
                if (!ws) ns.error = ERR_SEPARATOR;
                else if (lat.kind == KIND_STAT) begin
                  ns.phase = PH_NUM1;
                  ns.digits_seen = 1'b0;
                end else begin
                  ns.phase = PH_LEAD;
                  ns.slice_start = 11'(p + 1'b1);
                end
              end else if (b < 8'd32 && b != 8'd9) begin
                ns.error = ERR_CONTROL;
              end else if (lat.kind == KIND_STAT) begin
                pair = 1'b1;
              end else if (lat.phase == PH_LEAD) begin
                if (ws) ns.slice_start = 11'(p + 1'b1);
                else ns.phase = PH_TEXT;
              end
            end
          endcase
          // Two-number body shared by STAT and LIST lines.
          if (pair) begin
            if (lat.phase == PH_NUM1 || lat.phase == PH_NUM2) begin
              if (dig) begin
                if (ovf) ns.phase = PH_FAIL;
                else begin
                  if (lat.phase == PH_NUM1) ns.value_one = acc[63:0];
                  else ns.value_two = acc[63:0];
                  ns.digits_seen = 1'b1;
                end
              end else if (ws) begin
                if (lat.digits_seen) begin
                  ns.phase = (lat.phase == PH_NUM1) ? PH_NUM2 : PH_TAIL;
                  ns.digits_seen = 1'b0;
                end
              end else begin
                ns.phase = PH_FAIL;
              end
            end else if (lat.phase == PH_TAIL) begin
              if (!ws) ns.phase = PH_FAIL;
            end else begin
              ns.phase = PH_FAIL;
            end
          end
        end
      end
    end
  end

  always_comb begin
    logic [10:0] np11;
    logic [10:0] nl;
    logic        done;
    logic [3:0]  code;
    np11 = 11'(np);
    nl = 11'd0;
    code = ns.error;
    done = (ns.phase == PH_NUM2 && ns.digits_seen) || ns.phase == PH_TAIL;
    result = '0;
    if (code == ERR_NONE) begin
      unique case (ns.kind)
        KIND_STAT: begin
          if (ns.phase == PH_PRE) code = ERR_PREFIX;
          else if (!ns.ok || !done) code = ERR_STAT;
          else begin
            result.first_number = ns.value_one;
            result.second_number = ns.value_two;
          end
        end
        KIND_LIST: begin
          if (!done || ns.value_one == 64'd0) code = ERR_LIST;
          else begin
            result.first_number = ns.value_one;
            result.second_number = ns.value_two;
          end
        end
        KIND_UIDL: begin
          if (ns.phase == PH_NUM1) code = ERR_UIDL_NUM;
          else if (ns.phase == PH_LEAD) code = ERR_EMPTY_ID;
          else begin
            result.first_number = ns.value_one;
            result.text_offset = ns.slice_start;
            result.text_length = np11 - ns.slice_start;
          end
        end
        KIND_CAPA: begin
          if (ns.phase == PH_CNAME) begin
            if (np == '0) code = ERR_CAP_EMPTY;
            nl = np11;
            result.text_offset = np11;
          end else begin
            nl = ns.name_len;
            result.text_offset = ns.slice_start;
            result.text_length = np11 - ns.slice_start;
          end
          result.name_length = nl;
          // Names of 15 or more bytes have cleared every mask bit already.
          for (int i = CAP_COUNT - 1; i >= 0; i--) begin
            if (ns.match_mask[i] && {7'd0, CAP_LEN[i]} == nl) begin
              result.capability_code = 4'(i + 1);
            end
          end
        end
        default: begin
          if (ns.phase == PH_PRE) code = ERR_PREFIX;
          else begin
            result.reply_ok = ns.ok;
            result.text_offset = ns.slice_start;
            result.text_length = np11 - ns.slice_start;
          end
        end
      endcase
    end
    if (code != ERR_NONE) result = '0;
    result.error_code = code;
  end

  assign state_next = item.line_end ? STATE_RESET : ns;
  assign pos_next = item.line_end ? '0 : np;

endmodule
